// ----- rtl/hst_pkg.sv -----
// ----------------------------------------------------------------------------
// hst_pkg: shared types and constants of the hermite segment tessellator
// Widths, controller command and status words, multiplier operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hst_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int T_W     = 16;
  localparam int WGT_W   = 32;
  localparam int PROD_W  = 64;

  // run length limit and point index width
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);

  // step register reset value, Q0.16
  localparam logic [T_W-1:0] STEP_RESET = 16'd1311;

  // one segment word
  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] start_tangent_x;
    logic signed [COORD_W-1:0] start_tangent_y;
    logic signed [COORD_W-1:0] end_tangent_x;
    logic signed [COORD_W-1:0] end_tangent_y;
  } seg_t;

  // one point word
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [IDX_W-1:0]          point_index;
    logic                      last_point;
  } point_t;

  // shared multiplier operations
  typedef enum logic [1:0] {
    MUL_NONE  = 2'd0,
    MUL_TT    = 2'd1,
    MUL_T2T   = 2'd2,
    MUL_COORD = 2'd3
  } mul_op_t;

  // multiplier operation with coordinate term select
  // term bit 2: y axis, bits 1:0: start, end, start tangent, end tangent
  typedef struct packed {
    mul_op_t    op;
    logic [2:0] term;
  } mul_cmd_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    mul_cmd_t mul;
    logic     wgt_en;
    logic     emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic last;
  } dp_status_t;

endpackage

// ----- rtl/hst_if.sv -----
// ----------------------------------------------------------------------------
// hst_if: valid/ready channels of the hermite segment tessellator
// Segment channel in, point channel out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hst_seg_if;
  logic                               valid;
  logic                               ready;
  logic signed [hst_pkg::COORD_W-1:0] start_x;
  logic signed [hst_pkg::COORD_W-1:0] start_y;
  logic signed [hst_pkg::COORD_W-1:0] end_x;
  logic signed [hst_pkg::COORD_W-1:0] end_y;
  logic signed [hst_pkg::COORD_W-1:0] start_tangent_x;
  logic signed [hst_pkg::COORD_W-1:0] start_tangent_y;
  logic signed [hst_pkg::COORD_W-1:0] end_tangent_x;
  logic signed [hst_pkg::COORD_W-1:0] end_tangent_y;

  modport source (
    output valid, start_x, start_y, end_x, end_y,
           start_tangent_x, start_tangent_y, end_tangent_x, end_tangent_y,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y,
           start_tangent_x, start_tangent_y, end_tangent_x, end_tangent_y,
    output ready
  );
endinterface

interface hst_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [hst_pkg::COORD_W-1:0] point_x;
  logic signed [hst_pkg::COORD_W-1:0] point_y;
  logic [hst_pkg::IDX_W-1:0]          point_index;
  logic                               last_point;

  modport source (
    output valid, point_x, point_y, point_index, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_index, last_point,
    output ready
  );
endinterface

// ----- rtl/hst_ctrl.sv -----
// ----------------------------------------------------------------------------
// hst_ctrl: sequencer of the hermite segment tessellator
// Steps the shared multiplier through t^2, t^3 and the eight coordinate
// products of each point, then hands the point to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hst_pkg::dp_status_t status,
  output hst_pkg::dp_cmd_t    cmd
);
  import hst_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_T2   = 7'b0000010,
    S_T3   = 7'b0000100,
    S_WGT  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] term, term_next;

  // state and product counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term  <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    term_next    = term;
    cmd.load     = 1'b0;
    cmd.mul.op   = MUL_NONE;
    cmd.mul.term = term;
    cmd.wgt_en   = 1'b0;
    cmd.emit     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_T2;
        end
      end
      S_T2: begin
        cmd.mul.op = MUL_TT;
        state_next = S_T3;
      end
      S_T3: begin
        cmd.mul.op = MUL_T2T;
        state_next = S_WGT;
      end
      S_WGT: begin
        cmd.wgt_en = 1'b1;
        term_next  = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul.op = MUL_COORD;
        term_next  = term + 3'd1;
        if (term == 3'd7) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.last ? S_IDLE : S_T2;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/hst_datapath.sv -----
// ----------------------------------------------------------------------------
// hst_datapath: arithmetic of the hermite segment tessellator
// Holds the segment, t and the step register, one shared 33x33 multiplier
// with a registered product, basis weights, two accumulators and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hst_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [hst_pkg::T_W-1:0]       cfg_wr_data,
  input  hst_pkg::seg_t                 seg_in,
  input  hst_pkg::dp_cmd_t              cmd,
  output hst_pkg::dp_status_t           status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hst_pkg::point_t               out_word
);
  import hst_pkg::*;

  localparam logic signed [51:0] ONE_Q48   = 52'sh1_0000_0000_0000;
  localparam logic signed [51:0] HALF_Q18  = 52'sd131072;
  localparam logic signed [63:0] HALF_Q30  = 64'sd536870912;
  localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;

  // round a Q.48 weight half up to Q.30
  function automatic logic signed [WGT_W-1:0] round_weight(input logic signed [51:0] w);
    logic signed [51:0] s;
    s = w + HALF_Q18;
    return s[49:18];
  endfunction

  // round a Q.30 sum half up and saturate to a coordinate
  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [63:0] acc);
    logic signed [63:0] s;
    logic        [33:0] r;
    s = acc + HALF_Q30;
    r = s[63:30];
    if (r[33:31] == 3'b000 || r[33:31] == 3'b111) begin
      return r[31:0];
    end else if (r[33]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  logic [T_W-1:0]                   step_size;
  seg_t                             seg;
  logic [T_W-1:0]                   t;
  logic [IDX_W-1:0]                 n;
  logic [T_W:0]                     t_sum;
  logic [31:0]                      t2;
  logic signed [WGT_W-1:0]          wgt [4];
  logic signed [32:0]               mul_a, mul_b;
  logic signed [65:0]               mul_full;
  logic signed [PROD_W-1:0]         prod;
  mul_cmd_t                         tag;
  logic signed [PROD_W-1:0]         acc_x, acc_y;
  logic signed [COORD_W-1:0]        coord;
  logic signed [51:0]               t2q, t3q, tq;

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_RESET;
    end else if (cfg_wr_en) begin
      step_size <= cfg_wr_data;
    end
  end

  // end of run: index limit or t reaching one
  assign t_sum         = {1'b0, t} + {1'b0, step_size};
  assign status.last   = (n == IDX_W'(MAX_POINTS - 1)) || t_sum[T_W];
  assign status.out_free = !out_valid || out_ready;

  // segment, t and point counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seg <= seg_in;
      t   <= '0;
      n   <= '0;
    end else if (cmd.emit) begin
      t <= t_sum[T_W-1:0];
      n <= n + IDX_W'(1);
    end
  end

  // coordinate term select
  always_comb begin
    unique case (cmd.mul.term)
      3'd0: coord = seg.start_x;
      3'd1: coord = seg.end_x;
      3'd2: coord = seg.start_tangent_x;
      3'd3: coord = seg.end_tangent_x;
      3'd4: coord = seg.start_y;
      3'd5: coord = seg.end_y;
      3'd6: coord = seg.start_tangent_y;
      default: coord = seg.end_tangent_y;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    unique case (cmd.mul.op)
      MUL_TT: begin
        mul_a = signed'({17'd0, t});
        mul_b = signed'({17'd0, t});
      end
      MUL_T2T: begin
        mul_a = signed'({1'b0, prod[31:0]});
        mul_b = signed'({17'd0, t});
      end
      MUL_COORD: begin
        mul_a = 33'(coord);
        mul_b = 33'(wgt[cmd.mul.term[1:0]]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // product register and its operation tag
  always_ff @(posedge clk) begin
    prod <= mul_full[PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.op   <= MUL_NONE;
      tag.term <= '0;
    end else begin
      tag <= cmd.mul;
    end
  end

  // t squared capture
  always_ff @(posedge clk) begin
    if (tag.op == MUL_TT) begin
      t2 <= prod[31:0];
    end
  end

  // basis weights in Q.48, from t, t^2 and t^3 (the product register)
  assign t2q = signed'({4'd0, t2, 16'd0});
  assign t3q = signed'({4'd0, prod[47:0]});
  assign tq  = signed'({4'd0, t, 32'd0});

  always_ff @(posedge clk) begin
    if (cmd.wgt_en) begin
      wgt[0] <= round_weight((t3q <<< 1) - (t2q + (t2q <<< 1)) + ONE_Q48);
      wgt[1] <= round_weight((t2q + (t2q <<< 1)) - (t3q <<< 1));
      wgt[2] <= round_weight(t3q - (t2q <<< 1) + tq);
      wgt[3] <= round_weight(t3q - t2q);
    end
  end

  // coordinate accumulators
  always_ff @(posedge clk) begin
    if (tag.op == MUL_COORD) begin
      if (!tag.term[2]) begin
        acc_x <= (tag.term[1:0] == 2'd0) ? prod : acc_x + prod;
      end else begin
        acc_y <= (tag.term[1:0] == 2'd0) ? prod : acc_y + prod;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.point_x     <= round_sat(acc_x);
      out_word.point_y     <= round_sat(acc_y);
      out_word.point_index <= n;
      out_word.last_point  <= status.last;
    end
  end

endmodule

// ----- rtl/hermite_segment_tessellator_unit.sv -----
// ----------------------------------------------------------------------------
// hermite_segment_tessellator_unit: cubic hermite segment to point run
// Takes one 2D cubic hermite segment (endpoints and tangents, signed Q16.16)
// and emits one point per step of t in Q0.16, from 0 by step_size while t is
// below one, at most 64 points, each rounded and saturated, the last one
// flagged. A segment is accepted only when the previous run is finished.
// All ten products of a point (t^2, t^3 and eight coordinate-weight products)
// go through one shared 33x33 multiplier, one product a cycle; the weights
// are registered after t^3, and a final accumulate and the output load follow
// the coordinate products. A stalled output word holds the run in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hermite_segment_tessellator_unit (
  input  logic                    clk,
  input  logic                    rst,
  hst_seg_if.sink                 seg_in,
  hst_point_if.source             point_out,
  input  logic                    cfg_wr_en,
  input  logic [hst_pkg::T_W-1:0] cfg_wr_data
);
  import hst_pkg::*;

  seg_t       seg_word;
  point_t     point_word;
  dp_cmd_t    cmd;
  dp_status_t status;

  // segment word from the input channel
  assign seg_word.start_x         = seg_in.start_x;
  assign seg_word.start_y         = seg_in.start_y;
  assign seg_word.end_x           = seg_in.end_x;
  assign seg_word.end_y           = seg_in.end_y;
  assign seg_word.start_tangent_x = seg_in.start_tangent_x;
  assign seg_word.start_tangent_y = seg_in.start_tangent_y;
  assign seg_word.end_tangent_x   = seg_in.end_tangent_x;
  assign seg_word.end_tangent_y   = seg_in.end_tangent_y;

  // sequencer
  hst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (seg_in.valid),
    .in_ready (seg_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic
  hst_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .seg_in      (seg_word),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (point_out.valid),
    .out_ready   (point_out.ready),
    .out_word    (point_word)
  );

  // point word to the output channel
  assign point_out.point_x     = point_word.point_x;
  assign point_out.point_y     = point_word.point_y;
  assign point_out.point_index = point_word.point_index;
  assign point_out.last_point  = point_word.last_point;

endmodule

// ----- tb/sv/hermite_segment_tessellator_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_segment_tessellator_unit_test: self-checking bench of the tessellator
// Sends cubic hermite segments with random gaps and stalls the point side at
// random. Every point of each run is worked out in fixed point when its segment
// word is accepted, and each point word is compared in order, field by field.
// The step register goes through reset, zero, one, the bounds and random values.
// ----------------------------------------------------------------------------

module hermite_segment_tessellator_unit_test;
  import hst_pkg::*;

  localparam int unsigned T_ONE = 1 << T_W;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS = 50;
  localparam int RANDOM_PHASES = 7;
  localparam int MAX_REPORTS = 10;

  // expected point words of the accepted segments, oldest first
  class curve_points;
    point_t pending_points[$];
    logic [T_W-1:0] step;
    int mismatches;

    function new();
      step = STEP_RESET;
      mismatches = 0;
    endfunction

    // Q.48 weight to Q.30, round half up
    static function longint round_weight(longint w);
      return (w + 64'sd131072) >>> 18;
    endfunction

    // Q.30 scaled sum to Q16.16, round half up, saturate
    static function logic [COORD_W-1:0] round_coord(longint acc);
      longint unsigned biased;
      longint r;
      biased = acc + 64'h8000_0000_2000_0000;
      r = longint'(biased >> 30) - (64'sd1 <<< 33);
      if (r > 64'sd2147483647)
        r = 64'sd2147483647;
      if (r < -64'sd2147483648)
        r = -64'sd2147483648;
      return r[COORD_W-1:0];
    endfunction

    // all points of one segment run
    function void add_segment(seg_t s);
      longint u, t2, t3, h00, h10, h01, h11, ax, ay;
      int unsigned t;
      int n;
      point_t p;
      t = 0;
      n = 0;
      while (t < T_ONE && n < MAX_POINTS) begin
        u = longint'(t);
        t2 = (u * u) <<< 16;
        t3 = u * u * u;
        h00 = round_weight(2 * t3 - 3 * t2 + (64'sd1 <<< 48));
        h10 = round_weight(t3 - 2 * t2 + (u <<< 32));
        h01 = round_weight(3 * t2 - 2 * t3);
        h11 = round_weight(t3 - t2);
        ax = longint'($signed(s.start_x)) * h00 + longint'($signed(s.end_x)) * h01
           + longint'($signed(s.start_tangent_x)) * h10
           + longint'($signed(s.end_tangent_x)) * h11;
        ay = longint'($signed(s.start_y)) * h00 + longint'($signed(s.end_y)) * h01
           + longint'($signed(s.start_tangent_y)) * h10
           + longint'($signed(s.end_tangent_y)) * h11;
        p.point_x = round_coord(ax);
        p.point_y = round_coord(ay);
        p.point_index = n[IDX_W-1:0];
        p.last_point = (t + step >= T_ONE) || (n == MAX_POINTS - 1);
        pending_points = {pending_points, p};
        n++;
        t += step;
      end
    endfunction

    // one accepted point word against the oldest expected one
    function void check_point(point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected point: x=%0d y=%0d index=%0d last=%0b",
                   $signed(got.point_x), $signed(got.point_y), got.point_index,
                   got.last_point);
      end else begin
        want = pending_points.pop_front();
        if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
            got.point_index !== want.point_index || got.last_point !== want.last_point) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("point mismatch: expected x=%0d y=%0d index=%0d last=%0b",
                     $signed(want.point_x), $signed(want.point_y), want.point_index,
                     want.last_point);
            $display("                actual   x=%0d y=%0d index=%0d last=%0b",
                     $signed(got.point_x), $signed(got.point_y), got.point_index,
                     got.last_point);
          end
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [T_W-1:0] cfg_wr_data;
  int unsigned cycle_count = 0;

  hst_seg_if seg_bus();
  hst_point_if point_bus();

  curve_points expected_run = new();

  hermite_segment_tessellator_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .seg_in      (seg_bus),
    .point_out   (point_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4, 5: return $urandom();
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  function automatic seg_t rand_segment();
    seg_t s;
    for (int k = 0; k < 8; k++)
      s[k*COORD_W +: COORD_W] = pick_coord();
    return s;
  endfunction

  function automatic seg_t same_everywhere(logic [COORD_W-1:0] v);
    return {8{v}};
  endfunction

  // present one segment word after a gap, return at the edge that takes it
  task automatic send_segment(seg_t s, int gap);
    if (gap > 0) begin
      seg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_bus.valid           <= 1'b1;
    seg_bus.start_x         <= s.start_x;
    seg_bus.start_y         <= s.start_y;
    seg_bus.end_x           <= s.end_x;
    seg_bus.end_y           <= s.end_y;
    seg_bus.start_tangent_x <= s.start_tangent_x;
    seg_bus.start_tangent_y <= s.start_tangent_y;
    seg_bus.end_tangent_x   <= s.end_tangent_x;
    seg_bus.end_tangent_y   <= s.end_tangent_y;
    @(posedge clk);
    while (!seg_bus.ready)
      @(posedge clk);
    expected_run.add_segment(s);
  endtask

  // hold the segment side until every expected point is out, then settle
  task automatic drain();
    seg_bus.valid <= 1'b0;
    while (expected_run.pending_points.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // step register write, block idle
  task automatic write_step(logic [T_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    expected_run.step = v;
  endtask

  // point side: ready in runs with random stalls
  initial begin : point_sink
    int run_len;
    int gap;
    point_bus.ready = 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      point_bus.ready <= 1'b1;
      if ($urandom_range(0, 19) == 0)
        run_len = $urandom_range(100, 300);
      else
        run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        point_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // point word monitor
  always @(posedge clk) begin : point_monitor
    point_t seen;
    if (!rst && point_bus.valid && point_bus.ready) begin
      seen.point_x = point_bus.point_x;
      seen.point_y = point_bus.point_y;
      seen.point_index = point_bus.point_index;
      seen.last_point = point_bus.last_point;
      expected_run.check_point(seen);
    end
  end

  initial begin : stimulus
    seg_t s;
    logic [T_W-1:0] phase_step;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    seg_bus.valid = 1'b0;
    seg_bus.start_x = '0;
    seg_bus.start_y = '0;
    seg_bus.end_x = '0;
    seg_bus.end_y = '0;
    seg_bus.start_tangent_x = '0;
    seg_bus.start_tangent_y = '0;
    seg_bus.end_tangent_x = '0;
    seg_bus.end_tangent_y = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset step: zeros and both coordinate extremes, saturating
    send_segment(same_everywhere(32'h0000_0000), 0);
    send_segment(same_everywhere(32'h7FFF_FFFF), 0);
    send_segment(same_everywhere(32'h8000_0000), pick_gap());
    // unit chord, no tangents
    s = same_everywhere(32'h0000_0000);
    s.end_x = 32'h0001_0000;
    s.end_y = 32'hFFFF_0000;
    send_segment(s, pick_gap());
    // opposite extremes on endpoints and tangents
    s.start_x = 32'h7FFF_FFFF;
    s.start_y = 32'h8000_0000;
    s.end_x = 32'h8000_0000;
    s.end_y = 32'h7FFF_FFFF;
    s.start_tangent_x = 32'h8000_0000;
    s.start_tangent_y = 32'h7FFF_FFFF;
    s.end_tangent_x = 32'h7FFF_FFFF;
    s.end_tangent_y = 32'h8000_0000;
    send_segment(s, 0);
    drain();
    send_segment(rand_segment(), 0);
    drain();

    // largest step: two points per run
    write_step(16'hFFFF);
    send_segment(same_everywhere(32'h7FFF_FFFF), 0);
    send_segment(rand_segment(), 0);
    send_segment(rand_segment(), pick_gap());
    drain();

    // zero step: run of copies of the start point
    write_step(16'h0000);
    send_segment(rand_segment(), 0);
    send_segment(same_everywhere(32'h8000_0000), 0);
    drain();

    // tiny step: run cut at the point limit
    write_step(16'h0001);
    send_segment(rand_segment(), 0);
    send_segment(rand_segment(), pick_gap());
    drain();

    // lower bound of the useful step range
    write_step(16'd1025);
    send_segment(rand_segment(), 0);
    send_segment(rand_segment(), 0);
    drain();

    // random segments over several step settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: phase_step = STEP_RESET;
        1: phase_step = 16'hFFFF;
        2: phase_step = T_W'($urandom_range(1025, 65535));
        3: phase_step = T_W'($urandom_range(16384, 65535));
        4: phase_step = 16'h0000;
        5: phase_step = T_W'($urandom_range(0, 65535));
        default: phase_step = 16'd1025;
      endcase
      write_step(phase_step);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 24) == 0)
          drain();
        send_segment(rand_segment(), pick_gap());
      end
      drain();
    end

    if (expected_run.mismatches == 0 && expected_run.pending_points.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hst_pkg.sv
rtl/hst_if.sv
rtl/hst_ctrl.sv
rtl/hst_datapath.sv
rtl/hermite_segment_tessellator_unit.sv
tb/sv/hermite_segment_tessellator_unit_test.sv
